### hdl/hsv2rgb_pkg.sv
// Shared types and constants of the HSV to RGB converter.
// Used by hsv2rgb_sector, hsv2rgb_scale and hsv_to_rgb_converter_core.
package hsv2rgb_pkg;

    localparam int unsigned SectorUnits = 3840;
    localparam int unsigned FullTurn    = 23040;
    localparam int unsigned NumLanes    = 3;

    localparam int unsigned CH_Q = 0;
    localparam int unsigned CH_T = 1;
    localparam int unsigned CH_P = 2;

    localparam logic [27:0] Den   = 28'd251654400;
    localparam logic [18:0] Recip = 19'((64'd1 << 46) / 64'd251654400);

    typedef enum logic [2:0] {
        SEC_R_TO_Y = 3'd0,
        SEC_Y_TO_G = 3'd1,
        SEC_G_TO_C = 3'd2,
        SEC_C_TO_B = 3'd3,
        SEC_B_TO_M = 3'd4,
        SEC_M_TO_R = 3'd5
    } t_sector;

    typedef struct packed {
        logic [14:0] hue;
        logic [15:0] saturation;
        logic [15:0] value_level;
    } t_hsv_item;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } t_rgb_item;

    typedef struct packed {
        t_sector          sector;
        logic [15:0]      sat;
        logic [15:0]      val;
        logic [2:0][11:0] gain;
    } t_scale_in;

    typedef struct packed {
        t_sector          sector;
        logic [15:0]      val;
        logic [2:0][15:0] chan;
    } t_scale_out;

endpackage

### hdl/hsv2rgb_sector.sv
// Hue wrap and sector split: two pipeline stages.
// Depends on hsv2rgb_pkg.
module hsv2rgb_sector (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  hsv2rgb_pkg::t_hsv_item i_item,
    output logic                   o_valid,
    input  logic                   i_stall,
    output hsv2rgb_pkg::t_scale_in o_item
);

    localparam logic [14:0] TurnLim = 15'(hsv2rgb_pkg::FullTurn);
    localparam logic [11:0] SecLen  = 12'(hsv2rgb_pkg::SectorUnits);

    logic        r_a_vld;
    logic [14:0] r_a_hw;
    logic [15:0] r_a_sat;
    logic [15:0] r_a_val;
    logic        r_b_vld;
    hsv2rgb_pkg::t_scale_in r_b_item;

    logic        w_rdy_a;
    logic        w_rdy_b;
    logic [14:0] n_a_hw;
    logic [14:0] w_base;
    logic [11:0] w_frac;
    hsv2rgb_pkg::t_scale_in n_b_item;

    assign w_rdy_b = !r_b_vld || !i_stall;
    assign w_rdy_a = !r_a_vld || w_rdy_b;
    assign o_stall = !w_rdy_a;
    assign o_valid = r_b_vld;
    assign o_item  = r_b_item;

    always_comb begin
        if (i_item.hue >= TurnLim) begin
            n_a_hw = i_item.hue - TurnLim;
        end else begin
            n_a_hw = i_item.hue;
        end
    end

    always_comb begin
        n_b_item = '0;
        if (r_a_hw >= 15'(5 * hsv2rgb_pkg::SectorUnits)) begin
            n_b_item.sector = hsv2rgb_pkg::SEC_M_TO_R;
            w_base          = 15'(5 * hsv2rgb_pkg::SectorUnits);
        end else if (r_a_hw >= 15'(4 * hsv2rgb_pkg::SectorUnits)) begin
            n_b_item.sector = hsv2rgb_pkg::SEC_B_TO_M;
            w_base          = 15'(4 * hsv2rgb_pkg::SectorUnits);
        end else if (r_a_hw >= 15'(3 * hsv2rgb_pkg::SectorUnits)) begin
            n_b_item.sector = hsv2rgb_pkg::SEC_C_TO_B;
            w_base          = 15'(3 * hsv2rgb_pkg::SectorUnits);
        end else if (r_a_hw >= 15'(2 * hsv2rgb_pkg::SectorUnits)) begin
            n_b_item.sector = hsv2rgb_pkg::SEC_G_TO_C;
            w_base          = 15'(2 * hsv2rgb_pkg::SectorUnits);
        end else if (r_a_hw >= 15'(hsv2rgb_pkg::SectorUnits)) begin
            n_b_item.sector = hsv2rgb_pkg::SEC_Y_TO_G;
            w_base          = 15'(hsv2rgb_pkg::SectorUnits);
        end else begin
            n_b_item.sector = hsv2rgb_pkg::SEC_R_TO_Y;
            w_base          = '0;
        end
        w_frac = 12'(r_a_hw - w_base);
        n_b_item.sat = r_a_sat;
        n_b_item.val = r_a_val;
        n_b_item.gain[hsv2rgb_pkg::CH_Q] = w_frac;
        n_b_item.gain[hsv2rgb_pkg::CH_T] = SecLen - w_frac;
        n_b_item.gain[hsv2rgb_pkg::CH_P] = SecLen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            if (w_rdy_a) begin
                r_a_vld <= i_valid;
            end
            if (w_rdy_b) begin
                r_b_vld <= r_a_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_a) begin
            r_a_hw  <= n_a_hw;
            r_a_sat <= i_item.saturation;
            r_a_val <= i_item.value_level;
        end
        if (w_rdy_b) begin
            r_b_item <= n_b_item;
        end
    end

endmodule

### hdl/hsv2rgb_scale.sv
// Three scaling lanes v*(1 - s*g/(65535*3840)), six pipeline stages, exact floor.
// Divides by a constant through a reciprocal estimate and one correction.
// Depends on hsv2rgb_pkg.
module hsv2rgb_scale (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  hsv2rgb_pkg::t_scale_in  i_item,
    output logic                    o_valid,
    input  logic                    i_stall,
    output hsv2rgb_pkg::t_scale_out o_item
);

    typedef struct packed {
        hsv2rgb_pkg::t_sector sector;
        logic [15:0]          val;
    } t_side;

    logic [6:1] r_vld;
    logic [7:1] w_rdy;
    t_side      r_side [1:6];

    logic [2:0][27:0] r_sg;
    logic [2:0][27:0] r_mul;
    logic [2:0][43:0] r_num3;
    logic [2:0][43:0] r_num4;
    logic [2:0][15:0] r_qe4;
    logic [2:0][43:0] r_num5;
    logic [2:0][43:0] r_prod5;
    logic [2:0][15:0] r_qe5;
    logic [2:0][15:0] r_quo6;

    logic [2:0][27:0] n_sg;
    logic [2:0][27:0] n_mul;
    logic [2:0][43:0] n_num3;
    logic [2:0][46:0] w_est;
    logic [2:0][43:0] n_prod5;
    logic [2:0][43:0] w_rem;
    logic [2:0][15:0] n_quo6;

    always_comb begin
        w_rdy[7] = !i_stall;
        for (int k = 6; k >= 1; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k + 1];
        end
    end

    assign o_stall = !w_rdy[1];
    assign o_valid = r_vld[6];

    always_comb begin
        for (int i = 0; i < hsv2rgb_pkg::NumLanes; i++) begin
            n_sg[i]    = 28'(i_item.sat) * 28'(i_item.gain[i]);
            n_mul[i]   = hsv2rgb_pkg::Den - r_sg[i];
            n_num3[i]  = 44'(r_side[2].val) * 44'(r_mul[i]);
            w_est[i]   = 47'(r_num3[i][43:16]) * 47'(hsv2rgb_pkg::Recip);
            n_prod5[i] = 44'(r_qe4[i]) * 44'(hsv2rgb_pkg::Den);
            w_rem[i]   = r_num5[i] - r_prod5[i];
            n_quo6[i]  = r_qe5[i] + 16'(w_rem[i] >= 44'(hsv2rgb_pkg::Den));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[1]) begin
                r_vld[1] <= i_valid;
            end
            for (int k = 2; k <= 6; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k - 1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_side[1] <= '{sector: i_item.sector, val: i_item.val};
            r_sg      <= n_sg;
        end
        for (int k = 2; k <= 6; k++) begin
            if (w_rdy[k]) begin
                r_side[k] <= r_side[k - 1];
            end
        end
        if (w_rdy[2]) begin
            r_mul <= n_mul;
        end
        if (w_rdy[3]) begin
            r_num3 <= n_num3;
        end
        if (w_rdy[4]) begin
            r_num4 <= r_num3;
            for (int i = 0; i < hsv2rgb_pkg::NumLanes; i++) begin
                r_qe4[i] <= w_est[i][45:30];
            end
        end
        if (w_rdy[5]) begin
            r_num5  <= r_num4;
            r_qe5   <= r_qe4;
            r_prod5 <= n_prod5;
        end
        if (w_rdy[6]) begin
            r_quo6 <= n_quo6;
        end
    end

    assign o_item.sector = r_side[6].sector;
    assign o_item.val    = r_side[6].val;
    assign o_item.chan   = r_quo6;

endmodule

### hdl/hsv_to_rgb_converter_core.sv
// Top level of the HSV to RGB converter: sector split, scaling lanes, channel routing.
// Depends on hsv2rgb_pkg, hsv2rgb_sector and hsv2rgb_scale.
//
// Usage:
//   Input channel: i_hsv carries hue (1/64 degree), saturation and value_level.
//   An item is taken at a rising edge with i_hsv_valid high and o_hsv_stall low.
//   Output channel: o_rgb carries red, green and blue, full scale 65535, with
//   only the top COLOR_BITS bits of each channel kept. An item is delivered at
//   a rising edge with o_rgb_valid high and i_rgb_stall low.
//   Pipeline: 2 stages of hue wrap and sector split, 6 stages of multiply,
//   reciprocal divide and correction, 1 stage of routing and masking.
//   Throughput: one item per cycle when nothing stalls; every stage is a
//   register with its own valid bit, and the two 16x28 multipliers per lane
//   are fully pipelined.
//   A hue of 23040 or more wraps once by 23040 before the sector split.
//   Stall: when i_rgb_stall is high, the output item holds and stages behind
//   it keep filling any empty slot; o_hsv_stall rises only once all stages
//   hold an item. Nothing is lost or repeated.
//   Reset: synchronous, active low; all valid bits clear, the pipeline empties.
module hsv_to_rgb_converter_core #(
    parameter int COLOR_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_hsv_valid,
    output logic                   o_hsv_stall,
    input  hsv2rgb_pkg::t_hsv_item i_hsv,
    output logic                   o_rgb_valid,
    input  logic                   i_rgb_stall,
    output hsv2rgb_pkg::t_rgb_item o_rgb
);

    localparam int          ChanBits = (COLOR_BITS > 16) ? 16 :
                                       (COLOR_BITS < 1) ? 1 : COLOR_BITS;
    localparam logic [15:0] ChanMask = 16'hFFFF << (16 - ChanBits);

    logic                    w_sec_vld;
    logic                    w_sec_stall;
    hsv2rgb_pkg::t_scale_in  w_sec;
    logic                    w_scl_vld;
    logic                    w_scl_stall;
    hsv2rgb_pkg::t_scale_out w_scl;

    logic                    r_out_vld;
    hsv2rgb_pkg::t_rgb_item  r_out;
    hsv2rgb_pkg::t_rgb_item  n_out;
    logic                    w_rdy_out;
    logic [15:0]             w_q;
    logic [15:0]             w_t;
    logic [15:0]             w_p;
    logic [15:0]             w_v;

    hsv2rgb_sector u_sector (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_hsv_valid),
        .o_stall (o_hsv_stall),
        .i_item  (i_hsv),
        .o_valid (w_sec_vld),
        .i_stall (w_sec_stall),
        .o_item  (w_sec)
    );

    hsv2rgb_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sec_vld),
        .o_stall (w_sec_stall),
        .i_item  (w_sec),
        .o_valid (w_scl_vld),
        .i_stall (w_scl_stall),
        .o_item  (w_scl)
    );

    assign w_rdy_out   = !r_out_vld || !i_rgb_stall;
    assign w_scl_stall = !w_rdy_out;

    assign w_q = w_scl.chan[hsv2rgb_pkg::CH_Q];
    assign w_t = w_scl.chan[hsv2rgb_pkg::CH_T];
    assign w_p = w_scl.chan[hsv2rgb_pkg::CH_P];
    assign w_v = w_scl.val;

    always_comb begin
        case (w_scl.sector)
            hsv2rgb_pkg::SEC_R_TO_Y: begin
                n_out = '{red: w_v, green: w_t, blue: w_p};
            end
            hsv2rgb_pkg::SEC_Y_TO_G: begin
                n_out = '{red: w_q, green: w_v, blue: w_p};
            end
            hsv2rgb_pkg::SEC_G_TO_C: begin
                n_out = '{red: w_p, green: w_v, blue: w_t};
            end
            hsv2rgb_pkg::SEC_C_TO_B: begin
                n_out = '{red: w_p, green: w_q, blue: w_v};
            end
            hsv2rgb_pkg::SEC_B_TO_M: begin
                n_out = '{red: w_t, green: w_p, blue: w_v};
            end
            hsv2rgb_pkg::SEC_M_TO_R: begin
                n_out = '{red: w_v, green: w_p, blue: w_q};
            end
            default: begin
                n_out = '{red: w_v, green: w_p, blue: w_q};
            end
        endcase
        n_out.red   = n_out.red & ChanMask;
        n_out.green = n_out.green & ChanMask;
        n_out.blue  = n_out.blue & ChanMask;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_rdy_out) begin
            r_out_vld <= w_scl_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_out) begin
            r_out <= n_out;
        end
    end

    assign o_rgb_valid = r_out_vld;
    assign o_rgb       = r_out;

`ifndef NO_ASSERTIONS
    a_chan_below_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_scl_vld |-> (w_q <= w_v) && (w_t <= w_v) && (w_p <= w_v))
        else $error("scaled channel exceeds value");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hsv_stall |-> (o_rgb_valid && i_rgb_stall && w_scl_vld && w_sec_vld))
        else $error("input stalled while pipeline has room");

    a_low_bits_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rgb_valid |-> (((o_rgb.red | o_rgb.green | o_rgb.blue) & ~ChanMask) == 16'd0))
        else $error("channel bits below COLOR_BITS not cleared");
`endif

endmodule

### dv/hsv_to_rgb_converter_core_tb.sv
// Self-checking testbench for hsv_to_rgb_converter_core: a queue-fed driver with bursts
// and gaps, a stalling monitor, and a fixed-point predictor of the RGB item.
// Depends on hsv2rgb_pkg and the converter RTL.
module hsv_to_rgb_converter_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          ColorBits = 16;
    localparam int          RandItems = 1950;
    localparam logic [63:0] FullScale = 64'd65535;

    logic                   clk        = 1'b0;
    logic                   rst_n      = 1'b0;
    logic                   hsv_valid  = 1'b0;
    hsv2rgb_pkg::t_hsv_item hsv_item   = '0;
    logic                   rgb_stall  = 1'b0;
    logic                   o_hsv_stall;
    logic                   o_rgb_valid;
    hsv2rgb_pkg::t_rgb_item o_rgb;

    hsv2rgb_pkg::t_hsv_item hsv_pending[$];
    hsv2rgb_pkg::t_rgb_item rgb_expected[$];
    int        drain_marks[$];
    int        sent_count     = 0;
    int        burst_left     = 0;
    int        gap_left       = 0;
    int        mismatch_count = 0;
    int        monitor_cycle  = 0;

    hsv_to_rgb_converter_core #(
        .COLOR_BITS (ColorBits)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_hsv_valid (hsv_valid),
        .o_hsv_stall (o_hsv_stall),
        .i_hsv       (hsv_item),
        .o_rgb_valid (o_rgb_valid),
        .i_rgb_stall (rgb_stall),
        .o_rgb       (o_rgb)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic hsv2rgb_pkg::t_rgb_item hsv_to_rgb_expect(hsv2rgb_pkg::t_hsv_item c);
        logic [63:0] hue, sat, val, frac, den, p, q, t, r, g, b, mask;
        int          bits;
        hsv2rgb_pkg::t_sector   sector;
        hsv2rgb_pkg::t_rgb_item rgb;
        hue = 64'(c.hue);
        sat = 64'(c.saturation);
        val = 64'(c.value_level);
        den = FullScale * 64'(hsv2rgb_pkg::SectorUnits);
        if (hue >= 64'(hsv2rgb_pkg::FullTurn)) hue -= 64'(hsv2rgb_pkg::FullTurn);
        sector = hsv2rgb_pkg::t_sector'(3'(hue / 64'(hsv2rgb_pkg::SectorUnits)));
        frac = hue % 64'(hsv2rgb_pkg::SectorUnits);
        p = val * (FullScale - sat) / FullScale;
        q = val * (den - sat * frac) / den;
        t = val * (den - sat * (64'(hsv2rgb_pkg::SectorUnits) - frac)) / den;
        case (sector)
            hsv2rgb_pkg::SEC_R_TO_Y: begin r = val; g = t;   b = p;   end
            hsv2rgb_pkg::SEC_Y_TO_G: begin r = q;   g = val; b = p;   end
            hsv2rgb_pkg::SEC_G_TO_C: begin r = p;   g = val; b = t;   end
            hsv2rgb_pkg::SEC_C_TO_B: begin r = p;   g = q;   b = val; end
            hsv2rgb_pkg::SEC_B_TO_M: begin r = t;   g = p;   b = val; end
            default:                 begin r = val; g = p;   b = q;   end
        endcase
        bits = (ColorBits > 16) ? 16 : (ColorBits < 1) ? 1 : ColorBits;
        mask = (64'hFFFF >> (16 - bits)) << (16 - bits);
        rgb.red   = 16'(r & mask);
        rgb.green = 16'(g & mask);
        rgb.blue  = 16'(b & mask);
        return rgb;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        mismatch_count++;
        if (mismatch_count <= 100)
            $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    endtask

    task automatic queue_item(int h, int s, int v);
        hsv2rgb_pkg::t_hsv_item c;
        c.hue         = 15'(h);
        c.saturation  = 16'(s);
        c.value_level = 16'(v);
        hsv_pending.push_back(c);
    endtask

    function automatic int pick_level();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0) return 0;
        if (sel == 1) return 65535;
        return $urandom_range(0, 65535);
    endfunction

    // driver: hold while stalled, pause at drain marks, else run bursts and gaps
    always @(posedge clk) begin
        if (!rst_n) begin
            hsv_valid <= 1'b0;
        end else if (!(hsv_valid && o_hsv_stall)) begin
            if (hsv_valid) begin
                rgb_expected.push_back(hsv_to_rgb_expect(hsv_item));
                sent_count++;
            end
            if (drain_marks.size() != 0 && sent_count == drain_marks[0]) begin
                hsv_valid <= 1'b0;
                if (rgb_expected.size() == 0) drain_marks.pop_front();
            end else if (gap_left != 0) begin
                gap_left--;
                hsv_valid <= 1'b0;
            end else if (hsv_pending.size() != 0) begin
                hsv_valid <= 1'b1;
                hsv_item  <= hsv_pending.pop_front();
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
                    gap_left   = $urandom_range(1, 8);
                end
            end else begin
                hsv_valid <= 1'b0;
            end
        end
    end

    // monitor: check each delivered item, stall in phases of varying density
    always @(posedge clk) begin
        hsv2rgb_pkg::t_rgb_item want;
        int        mode;
        if (!rst_n) begin
            rgb_stall <= 1'b0;
        end else begin
            if (o_rgb_valid && !rgb_stall) begin
                if (rgb_expected.size() == 0) begin
                    report_mismatch("unexpected item, red", int'(o_rgb.red), 0);
                end else begin
                    want = rgb_expected.pop_front();
                    if (o_rgb.red !== want.red)
                        report_mismatch("red", int'(o_rgb.red), int'(want.red));
                    if (o_rgb.green !== want.green)
                        report_mismatch("green", int'(o_rgb.green), int'(want.green));
                    if (o_rgb.blue !== want.blue)
                        report_mismatch("blue", int'(o_rgb.blue), int'(want.blue));
                end
            end
            monitor_cycle++;
            mode = (monitor_cycle / 700) % 4;
            case (mode)
                0:       rgb_stall <= 1'b0;
                1:       rgb_stall <= ($urandom_range(0, 3) == 0);
                2:       rgb_stall <= (monitor_cycle % 3 == 0);
                default: rgb_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    initial begin
        int h, sel;
        queue_item(0, 0, 0);
        queue_item(0, 65535, 65535);
        queue_item(3839, 65535, 65535);
        queue_item(3840, 65535, 65535);
        queue_item(7680, 65535, 65535);
        queue_item(11520, 65535, 65535);
        queue_item(15360, 65535, 65535);
        queue_item(19200, 65535, 65535);
        queue_item(23039, 65535, 65535);
        queue_item(23040, 65535, 65535);
        queue_item(23041, 40000, 50000);
        queue_item(26880, 65535, 65535);
        queue_item(32767, 65535, 65535);
        queue_item(32767, 0, 65535);
        queue_item(9000, 0, 65535);
        queue_item(9000, 65535, 0);
        queue_item(12345, 1, 1);
        for (int k = 0; k < 6; k++)
            queue_item(1920 + k * int'(hsv2rgb_pkg::SectorUnits), 'hA5A5, 'h5A5A);
        drain_marks.push_back(hsv_pending.size());
        drain_marks.push_back(hsv_pending.size() + 1000);
        for (int n = 0; n < RandItems; n++) begin
            sel = $urandom_range(0, 19);
            if (sel < 14)
                h = $urandom_range(0, hsv2rgb_pkg::FullTurn - 1);
            else if (sel < 17)
                h = $urandom_range(hsv2rgb_pkg::FullTurn, 32767);
            else
                h = $urandom_range(0, 6) * int'(hsv2rgb_pkg::SectorUnits)
                    + $urandom_range(0, 4) - 2;
            if (h < 0) h = 0;
            queue_item(h, pick_level(), pick_level());
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (hsv_pending.size() != 0 || hsv_valid || rgb_expected.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
